/* sv/osdrle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OSD run-length decoder package
// Shared types, operation codes and defaults for the OSD screen update block.
// ----------------------------------------------------------------------------
package osdrle_pkg;

	localparam int ROWS_DEF = 32;
	localparam int COLS_DEF = 64;

	// Escape byte that opens a counted run, and the byte that flips the bank.
	localparam logic [7:0] BYTE_ESC  = 8'h00;
	localparam logic [7:0] BYTE_BANK = 8'hFF;

	typedef enum logic [1:0] {
		FUNC_PACKET = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_WRITE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		PH_PLAIN  = 2'd0,
		PH_COUNT  = 2'd1,
		PH_RUN    = 2'd2,
		PH_SINGLE = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_READ,
		ST_WRITE,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic accept;
		logic run_step;
		logic rd_push;
		logic rmw_write;
		logic sweep;
	} dp_cmd_t;

	typedef struct packed {
		logic q_space;
		logic go_run;
		logic go_read;
		logic go_write;
		logic go_clear;
		logic run_last;
		logic sweep_last;
	} dp_sts_t;

	typedef struct packed {
		logic [8:0] char_code;
		logic       stopped;
	} res_t;

endpackage

/* sv/osdrle_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OSD run-length decoder channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface osdrle_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	logic       packet_last;
	logic [4:0] cell_row;
	logic [5:0] cell_col;

	modport source (output valid, func, data_byte, packet_last, cell_row, cell_col,
		input ready);
	modport sink (input valid, func, data_byte, packet_last, cell_row, cell_col,
		output ready);
endinterface

interface osdrle_rsp_if;
	logic       valid;
	logic       ready;
	logic [8:0] char_code;
	logic       packet_stopped;

	modport source (output valid, char_code, packet_stopped, input ready);
	modport sink (input valid, char_code, packet_stopped, output ready);
endinterface

/* sv/osdrle_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-port RAM
// Generic single-port memory with a registered read port.
// ----------------------------------------------------------------------------
module osdrle_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 2048,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rd_q <= mem_q[addr];
	end

	assign rdata = rd_q;

endmodule

/* sv/osdrle_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OSD run-length decoder controller
// Sequences runs, cell reads, read-modify-write and screen clearing.
// ----------------------------------------------------------------------------
module osdrle_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  osdrle_pkg::dp_sts_t sts,
	output osdrle_pkg::dp_cmd_t cmd
);
	import osdrle_pkg::*;

	state_t state_q;
	state_t state_n;

	// The screen memory is swept clean after reset before any beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.accept) begin
					if (sts.go_run) begin
						state_n = ST_RUN;
					end else if (sts.go_read) begin
						state_n = ST_READ;
					end else if (sts.go_write) begin
						state_n = ST_WRITE;
					end else if (sts.go_clear) begin
						state_n = ST_CLEAR;
					end
				end
			end
			ST_RUN: begin
				if (sts.run_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_READ:  state_n = ST_IDLE;
			ST_WRITE: state_n = ST_IDLE;
			ST_CLEAR: begin
				if (sts.sweep_last) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = sts.q_space;
				cmd.accept = in_valid && sts.q_space;
			end
			ST_RUN:   cmd.run_step  = 1'b1;
			ST_READ:  cmd.rd_push   = 1'b1;
			ST_WRITE: cmd.rmw_write = 1'b1;
			ST_CLEAR: cmd.sweep     = 1'b1;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_clear_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.go_clear) |=> (state_q == ST_CLEAR))
		else $error("clear beat did not start the sweep");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && sts.run_last) |=> (state_q == ST_IDLE))
		else $error("run did not finish after its last cell");
`endif

endmodule

/* sv/osdrle_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OSD run-length decoder datapath
// Packet parser, cursor, screen memory port and a two-entry result queue.
// ----------------------------------------------------------------------------
module osdrle_dp #(
	parameter int ROWS = osdrle_pkg::ROWS_DEF,
	parameter int COLS = osdrle_pkg::COLS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          func,
	input  logic [7:0]          data_byte,
	input  logic                packet_last,
	input  logic [4:0]          cell_row,
	input  logic [5:0]          cell_col,
	input  osdrle_pkg::dp_cmd_t cmd,
	output osdrle_pkg::dp_sts_t sts,
	osdrle_rsp_if.source        rsp
);
	import osdrle_pkg::*;

	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	func_t       func_c;
	logic        cell_ok;
	logic [AW-1:0] cell_addr;

	logic [AW-1:0] cursor_q;
	logic [AW-1:0] cursor_inc;
	logic          bank_q;
	phase_t        phase_q;
	logic [6:0]    run_len_q;
	logic          stop_q;
	logic          last_q;
	logic [7:0]    byte_q;
	logic [AW-1:0] cell_addr_q;
	logic [AW-1:0] sweep_q;

	phase_t     phase_n;
	logic       bank_n;
	logic [6:0] run_len_n;
	logic       stop_n;
	logic       put_now;
	logic       run_go;
	logic       pkt_acc;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [8:0]    ram_wdata;
	logic [8:0]    ram_rdata;

	res_t       ent0_q;
	res_t       ent1_q;
	logic [1:0] res_cnt_q;
	res_t       push_res;
	logic       push;
	logic       pop;

	assign func_c    = func_t'(func);
	assign cell_ok   = (32'(cell_row) < ROWS) && (32'(cell_col) < COLS);
	assign cell_addr = AW'(32'(cell_row) * COLS + 32'(cell_col));
	assign cursor_inc = (cursor_q == AW'(DEPTH - 1)) ? '0 : cursor_q + 1'b1;
	assign pkt_acc   = cmd.accept && (func_c == FUNC_PACKET);

	// Packet byte decode against the current parser state.
	always_comb begin
		phase_n   = phase_q;
		bank_n    = bank_q;
		run_len_n = run_len_q;
		stop_n    = stop_q;
		put_now   = 1'b0;
		run_go    = 1'b0;
		if (!stop_q) begin
			unique case (phase_q)
				PH_COUNT: begin
					if (data_byte[6:0] == 7'd0) begin
						stop_n  = 1'b1;
						phase_n = PH_PLAIN;
					end else begin
						bank_n    = bank_q ^ data_byte[7];
						run_len_n = data_byte[6:0];
						phase_n   = PH_RUN;
					end
				end
				PH_RUN: begin
					run_go  = 1'b1;
					phase_n = PH_PLAIN;
				end
				PH_SINGLE: begin
					put_now = 1'b1;
					phase_n = PH_PLAIN;
				end
				PH_PLAIN: begin
					if (data_byte == BYTE_ESC) begin
						phase_n = PH_COUNT;
					end else if (data_byte == BYTE_BANK) begin
						bank_n  = ~bank_q;
						phase_n = PH_SINGLE;
					end else begin
						put_now = 1'b1;
					end
				end
			endcase
		end
	end

	// Parser and cursor state. A run defers the end of packet to its last cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			bank_q    <= 1'b0;
			phase_q   <= PH_PLAIN;
			run_len_q <= 7'd0;
			stop_q    <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			if (pkt_acc) begin
				last_q <= packet_last;
				if (packet_last && !run_go) begin
					cursor_q  <= '0;
					bank_q    <= 1'b0;
					phase_q   <= PH_PLAIN;
					run_len_q <= 7'd0;
					stop_q    <= 1'b0;
				end else begin
					bank_q    <= bank_n;
					phase_q   <= phase_n;
					run_len_q <= run_len_n;
					stop_q    <= stop_n;
					if (put_now) begin
						cursor_q <= cursor_inc;
					end
				end
			end
			if (cmd.run_step) begin
				if (run_len_q == 7'd1) begin
					run_len_q <= 7'd0;
					if (last_q) begin
						cursor_q <= '0;
						bank_q   <= 1'b0;
						phase_q  <= PH_PLAIN;
						stop_q   <= 1'b0;
					end else begin
						cursor_q <= cursor_inc;
					end
				end else begin
					run_len_q <= run_len_q - 7'd1;
					cursor_q  <= cursor_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= (sweep_q == AW'(DEPTH - 1)) ? '0 : sweep_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q      <= data_byte;
			cell_addr_q <= cell_addr;
		end
	end

	// Screen memory port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = cursor_q;
		ram_wdata = {bank_q, data_byte};
		if (cmd.sweep) begin
			ram_we    = 1'b1;
			ram_addr  = sweep_q;
			ram_wdata = '0;
		end else if (cmd.run_step) begin
			ram_we    = 1'b1;
			ram_wdata = {bank_q, byte_q};
		end else if (cmd.rmw_write) begin
			ram_we    = 1'b1;
			ram_addr  = cell_addr_q;
			ram_wdata = {ram_rdata[8], byte_q};
		end else if (cmd.accept) begin
			case (func_c) inside
				FUNC_PACKET:          ram_we   = put_now;
				FUNC_READ, FUNC_WRITE: ram_addr = cell_addr;
				default: ;
			endcase
		end
	end

	osdrle_ram #(
		.WIDTH (9),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Result queue: reads inside the screen push when the memory data returns, all else at accept.
	assign push = (cmd.accept && !(func_c == FUNC_READ && cell_ok)) || cmd.rd_push;
	assign pop  = rsp.valid && rsp.ready;
	assign push_res.char_code = cmd.rd_push ? ram_rdata : 9'd0;
	assign push_res.stopped   = pkt_acc ? stop_n : stop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
		end else begin
			res_cnt_q <= res_cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && res_cnt_q == 2'd1) begin
				ent0_q <= push_res;
			end else begin
				ent0_q <= ent1_q;
			end
			if (push && res_cnt_q == 2'd2) begin
				ent1_q <= push_res;
			end
		end else if (push) begin
			if (res_cnt_q == 2'd0) begin
				ent0_q <= push_res;
			end else begin
				ent1_q <= push_res;
			end
		end
	end

	assign rsp.valid          = (res_cnt_q != 2'd0);
	assign rsp.char_code      = ent0_q.char_code;
	assign rsp.packet_stopped = ent0_q.stopped;

	assign sts.q_space    = (res_cnt_q != 2'd2);
	assign sts.go_run     = (func_c == FUNC_PACKET) && run_go;
	assign sts.go_read    = (func_c == FUNC_READ) && cell_ok;
	assign sts.go_write   = (func_c == FUNC_WRITE) && cell_ok;
	assign sts.go_clear   = (func_c == FUNC_CLEAR);
	assign sts.run_last   = (run_len_q == 7'd1);
	assign sts.sweep_last = (sweep_q == AW'(DEPTH - 1));

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (res_cnt_q != 2'd2 || pop))
		else $error("result queue overflow");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run_step |-> (run_len_q != 7'd0))
		else $error("run step with an empty run count");
`endif

endmodule

/* sv/osd_rle_screen_update_top.sv */
// A packet byte is done at accept; a run byte then holds the input while it writes its cells.
// A cell read or write inside the screen then passes through its read or write state, while
// one outside it is done at accept; a clear sweeps every cell, and input ready also drops
// while two results wait. A result is queued when its beat is accepted, a cell read inside
// the screen from the read state; a run or a clear stalls the input but not its own result.
// After reset, a clearing pass over every cell zeroes the screen before any beat is taken.
// ----------------------------------------------------------------------------
// OSD run-length screen update, top level
// Decodes run-length coded OSD packets into a 9-bit character screen and
// serves cell reads, cell writes and screen clears.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module osd_rle_screen_update_top #(
	parameter int ROWS = osdrle_pkg::ROWS_DEF,
	parameter int COLS = osdrle_pkg::COLS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	osdrle_req_if.sink   req,
	osdrle_rsp_if.source rsp
);
	import osdrle_pkg::*;

	// The controller owns the request handshake and steps through the multi-cycle
	// operations: a run writes one cell per cycle, a read waits in the read state for
	// the registered memory data, a cell write reads first to keep the bank bit, and a
	// clear sweeps every cell once.
	dp_cmd_t cmd;
	dp_sts_t sts;

	osdrle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the parser, the cursor, the screen memory and a
	// two-beat result queue, so a finished result can wait while the next
	// beat is taken.
	osdrle_dp #(
		.ROWS (ROWS),
		.COLS (COLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.func        (req.func),
		.data_byte   (req.data_byte),
		.packet_last (req.packet_last),
		.cell_row    (req.cell_row),
		.cell_col    (req.cell_col),
		.cmd         (cmd),
		.sts         (sts),
		.rsp         (rsp)
	);

endmodule

/* test/osd_rle_screen_update_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OSD run-length screen update testbench
// Drives packet bytes, cell reads, cell writes and screen clears into the
// block and checks every result beat against a screen model that decodes the
// same byte stream in parallel. Both channels idle at random, and the run
// includes one long response hold-off and drains between test phases.
// ----------------------------------------------------------------------------
module osd_rle_screen_update_top_tb;
	import osdrle_pkg::*;

	localparam int ROWS         = ROWS_DEF;
	localparam int COLS         = COLS_DEF;
	// Counted beats to send in total, dead packet bytes aside; the random phase keeps going until it is reached.
	localparam int ITEMS_TARGET = 1650;
	// A clear or the clearing pass after reset holds off the request channel while the
	// screen is swept, and the long hold-off holds off the response channel. The limit is
	// several times the worst of these.
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 20000;
	// Cycles to linger once the last result is in.
	localparam int DRAIN_CYCLES = 16;

	// One request beat as the sender sees it.
	typedef struct {
		func_t      func;
		logic [7:0] data_byte;
		logic       packet_last;
		logic [4:0] cell_row;
		logic [5:0] cell_col;
	} osd_item_t;

	logic clk;
	logic arst_n;

	osdrle_req_if req_ch ();
	osdrle_rsp_if rsp_ch ();

	osd_rle_screen_update_top #(
		.ROWS(ROWS),
		.COLS(COLS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Screen model. It keeps its own copy of the screen and the packet parser
	// and works out the result beat for every accepted request beat.
	// ------------------------------------------------------------------------
	logic [8:0] screen_mem [ROWS*COLS];
	int         cur_row;
	int         cur_col;
	logic       bank_hi;
	phase_t     parse_ph;
	int         run_left;
	logic       stop_hit;

	// Results still owed by the block, oldest first.
	res_t       due_results [$];

	int         err_count;
	int         items_sent;
	int         results_seen;

	function automatic void end_of_packet();
		cur_row  = 0;
		cur_col  = 0;
		bank_hi  = 1'b0;
		parse_ph = PH_PLAIN;
		run_left = 0;
		stop_hit = 1'b0;
	endfunction

	function automatic void wipe_screen();
		foreach (screen_mem[i])
			screen_mem[i] = '0;
	endfunction

	// Writes one character at the cursor with the current bank as bit 8, then
	// steps the cursor row-major with a wrap back to the top-left cell.
	function automatic void place_char(logic [7:0] ch);
		if (cur_row < ROWS && cur_col < COLS)
			screen_mem[cur_row*COLS + cur_col] = {bank_hi, ch};
		cur_col++;
		if (cur_col >= COLS) begin
			cur_col = 0;
			cur_row++;
			if (cur_row >= ROWS)
				cur_row = 0;
		end
	endfunction

	function automatic void decode_byte(logic [7:0] b);
		if (stop_hit)
			return;
		case (parse_ph)
			PH_COUNT: begin
				// A zero count ends drawing for the rest of the packet.
				if (b[6:0] == 7'd0) begin
					stop_hit = 1'b1;
				end else begin
					if (b[7])
						bank_hi = ~bank_hi;
					run_left = int'(b[6:0]);
				end
				parse_ph = stop_hit ? PH_PLAIN : PH_RUN;
			end
			PH_RUN: begin
				repeat (run_left) place_char(b);
				run_left = 0;
				parse_ph = PH_PLAIN;
			end
			PH_SINGLE: begin
				place_char(b);
				parse_ph = PH_PLAIN;
			end
			default: begin
				if (b == BYTE_ESC) begin
					parse_ph = PH_COUNT;
				end else if (b == BYTE_BANK) begin
					bank_hi  = ~bank_hi;
					parse_ph = PH_SINGLE;
				end else begin
					place_char(b);
				end
			end
		endcase
	endfunction

	function automatic res_t screen_step(osd_item_t it);
		res_t r;
		bit   in_range;
		int   idx;
		r        = '0;
		in_range = (it.cell_row < ROWS) && (it.cell_col < COLS);
		idx      = it.cell_row*COLS + it.cell_col;
		case (it.func)
			FUNC_PACKET: decode_byte(it.data_byte);
			FUNC_READ: begin
				if (in_range)
					r.char_code = screen_mem[idx];
			end
			FUNC_CLEAR: wipe_screen();
			default: begin
				// A cell write keeps the bank bit of the cell.
				if (in_range)
					screen_mem[idx][7:0] = it.data_byte;
			end
		endcase
		// The stop flag of the ending packet is still reported on its last beat.
		r.stopped = stop_hit;
		if (it.func == FUNC_PACKET && it.packet_last)
			end_of_packet();
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Result checking. Every accepted result beat is matched against the
	// oldest owed result, field by field.
	// ------------------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: result %0d: %s: got 0x%0h, expected 0x%0h", $time, results_seen,
			what, got, want);
		err_count++;
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_results.size() == 0) begin
				report_mismatch("result beat with none owed", int'(rsp_ch.char_code), 0);
			end else begin
				want = due_results.pop_front();
				if (rsp_ch.char_code !== want.char_code)
					report_mismatch("char_code", int'(rsp_ch.char_code),
						int'(want.char_code));
				if (rsp_ch.packet_stopped !== want.stopped)
					report_mismatch("packet_stopped", int'(rsp_ch.packet_stopped),
						int'(want.stopped));
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog. It counts cycles in which neither channel moves a beat; the
	// longest honest silence is a clear or the long response hold-off.
	// ------------------------------------------------------------------------
	int quiet_cycles;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Response side. It changes between three stall patterns now and then:
	// always ready, coin flips, and mostly ready with short stalls. A long
	// hold-off is requested by bumping hold_token from the sender side.
	// ------------------------------------------------------------------------
	int hold_token;
	int hold_len;
	int hold_seen;
	int hold_left;
	int stall_left;
	int rx_mode;
	int rx_mode_left;

	initial begin
		rsp_ch.ready <= 1'b0;
		hold_seen    = 0;
		hold_left    = 0;
		stall_left   = 0;
		rx_mode      = 0;
		rx_mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = hold_len;
			end
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(50, 400);
			end else begin
				rx_mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (rx_mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					default: begin
						if ($urandom_range(0, 5) == 0) begin
							stall_left   = $urandom_range(1, 7);
							rsp_ch.ready <= 1'b0;
						end else begin
							rsp_ch.ready <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Request side. Beats go out in bursts of random length with random gaps
	// in between, unless no_gaps is set for a stretch.
	// ------------------------------------------------------------------------
	bit offering;
	bit no_gaps;
	int burst_left;

	// Offers one beat, waits for it to be taken and books the owed result.
	// Unless a gap follows, the valid line is left high so the next beat can follow directly.
	task automatic send_beat(input osd_item_t it, input bit counted);
		req_ch.valid       <= 1'b1;
		req_ch.func        <= it.func;
		req_ch.data_byte   <= it.data_byte;
		req_ch.packet_last <= it.packet_last;
		req_ch.cell_row    <= it.cell_row;
		req_ch.cell_col    <= it.cell_col;
		offering = 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		due_results.insert(due_results.size(), screen_step(it));
		if (counted)
			items_sent++;
		if (!no_gaps) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				req_ch.valid <= 1'b0;
				offering = 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Stops offering and waits until every owed result has come back.
	task automatic drain_results();
		if (offering) begin
			req_ch.valid <= 1'b0;
			offering = 1'b0;
		end
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic osd_item_t packet_beat(logic [7:0] b, logic last);
		osd_item_t it;
		it.func        = FUNC_PACKET;
		it.data_byte   = b;
		it.packet_last = last;
		// The address fields mean nothing here but still get exercised.
		it.cell_row    = 5'($urandom);
		it.cell_col    = 6'($urandom);
		return it;
	endfunction

	function automatic osd_item_t cell_beat(func_t f, logic [4:0] row, logic [5:0] col,
		logic [7:0] data);
		osd_item_t it;
		it.func        = f;
		it.data_byte   = data;
		it.packet_last = 1'($urandom_range(0, 1));
		it.cell_row    = row;
		it.cell_col    = col;
		return it;
	endfunction

	// A random read or write, aimed at the top rows half the time since that
	// is where most packets draw. Clears are rare because each sweeps the whole
	// screen.
	task automatic send_cell_op();
		logic [4:0] row;
		logic [5:0] col;
		int         pick;
		row  = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
		col  = 6'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 60)
			send_beat(cell_beat(FUNC_READ, row, col, 8'($urandom)), 1'b1);
		else if (pick < 99)
			send_beat(cell_beat(FUNC_WRITE, row, col, 8'($urandom)), 1'b1);
		else
			send_beat(cell_beat(FUNC_CLEAR, row, col, 8'($urandom)), 1'b1);
	endtask

	// Builds one well-formed packet with random content and sends it, with
	// cell ops mixed in between its bytes. A long packet is made of big runs
	// so that the cursor wraps around the whole screen. Some packets end on
	// a stop code with junk behind it, some are cut inside an escape.
	task automatic send_packet(input bit long_pkt);
		logic [7:0] pkt_bytes [$];
		bit         dead_bytes [$];
		int         tokens;
		int         pick;
		int         run;
		bit         stopped;
		tokens  = long_pkt ? $urandom_range(40, 60) : $urandom_range(1, 14);
		stopped = 1'b0;
		for (int t = 0; t < tokens && !stopped; t++) begin
			pick = long_pkt ? 60 + $urandom_range(0, 33) : $urandom_range(0, 99);
			if (pick < 45) begin
				pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(1, 254)));
				dead_bytes.insert(dead_bytes.size(), 1'b0);
			end else if (pick < 60) begin
				pkt_bytes.insert(pkt_bytes.size(), BYTE_BANK);
				pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
				dead_bytes.insert(dead_bytes.size(), 1'b0);
				dead_bytes.insert(dead_bytes.size(), 1'b0);
			end else if (pick < 95) begin
				if (long_pkt)
					run = $urandom_range(64, 127);
				else if ($urandom_range(0, 9) < 7)
					run = $urandom_range(1, 16);
				else
					run = $urandom_range(17, 127);
				pkt_bytes.insert(pkt_bytes.size(), BYTE_ESC);
				pkt_bytes.insert(pkt_bytes.size(), {1'($urandom), 7'(run)});
				pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
				repeat (3) dead_bytes.insert(dead_bytes.size(), 1'b0);
			end else begin
				// Stop code, with or without the bank bit, then bytes that are ignored.
				pkt_bytes.insert(pkt_bytes.size(), BYTE_ESC);
				pkt_bytes.insert(pkt_bytes.size(), {1'($urandom), 7'd0});
				dead_bytes.insert(dead_bytes.size(), 1'b0);
				dead_bytes.insert(dead_bytes.size(), 1'b0);
				repeat ($urandom_range(0, 3)) begin
					pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
					dead_bytes.insert(dead_bytes.size(), 1'b1);
				end
				stopped = 1'b1;
			end
		end
		if (!stopped && $urandom_range(0, 9) == 0) begin
			// Escape cut off by the end of the packet.
			pkt_bytes.insert(pkt_bytes.size(), BYTE_ESC);
			dead_bytes.insert(dead_bytes.size(), 1'b0);
			if ($urandom_range(0, 1) == 0) begin
				pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(1, 255)));
				dead_bytes.insert(dead_bytes.size(), 1'b0);
			end
		end
		foreach (pkt_bytes[k]) begin
			if ($urandom_range(0, 99) < 15)
				send_cell_op();
			send_beat(packet_beat(pkt_bytes[k], k == pkt_bytes.size() - 1), !dead_bytes[k]);
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Plain characters, a bank flip with its single character, counted runs
	// with and without the bank bit, a full-length run of character zero, then
	// a stop code with ignored bytes up to the end of the packet.
	task automatic test_packet_decode();
		send_beat(packet_beat(8'h01, 1'b0), 1'b1);
		send_beat(packet_beat(8'hFE, 1'b0), 1'b1);
		send_beat(packet_beat(BYTE_BANK, 1'b0), 1'b1);
		send_beat(packet_beat(8'h80, 1'b0), 1'b1);
		send_beat(packet_beat(BYTE_ESC, 1'b0), 1'b1);
		send_beat(packet_beat(8'h03, 1'b0), 1'b1);
		send_beat(packet_beat(8'hAA, 1'b0), 1'b1);
		send_beat(packet_beat(BYTE_ESC, 1'b0), 1'b1);
		send_beat(packet_beat(8'hFF, 1'b0), 1'b1);
		send_beat(packet_beat(8'h00, 1'b0), 1'b1);
		send_beat(packet_beat(BYTE_ESC, 1'b0), 1'b1);
		send_beat(packet_beat(8'h80, 1'b0), 1'b1);
		send_beat(packet_beat(8'h41, 1'b0), 1'b0);
		send_beat(packet_beat(8'h42, 1'b1), 1'b0);
		send_beat(cell_beat(FUNC_READ, 5'd0, 6'd2, 8'hFF), 1'b1);
		send_beat(cell_beat(FUNC_READ, 5'd0, 6'd3, 8'h00), 1'b1);
	endtask

	// Packets that end in the middle of an escape or right after a bank flip.
	task automatic test_cut_escapes();
		send_beat(packet_beat(BYTE_ESC, 1'b1), 1'b1);
		send_beat(packet_beat(BYTE_ESC, 1'b0), 1'b1);
		send_beat(packet_beat(8'h05, 1'b1), 1'b1);
		send_beat(packet_beat(BYTE_BANK, 1'b1), 1'b1);
		send_beat(packet_beat(8'h7F, 1'b1), 1'b1);
	endtask

	// Cell writes keep the bank bit; the bottom-right corner of the screen; a clear.
	task automatic test_cell_ops();
		send_beat(cell_beat(FUNC_WRITE, 5'd0, 6'd2, 8'h55), 1'b1);
		send_beat(cell_beat(FUNC_WRITE, 5'd31, 6'd63, 8'hFF), 1'b1);
		send_beat(cell_beat(FUNC_READ, 5'd31, 6'd63, 8'h00), 1'b1);
		send_beat(cell_beat(FUNC_READ, 5'd0, 6'd2, 8'h00), 1'b1);
		send_beat(cell_beat(FUNC_CLEAR, 5'd31, 6'd63, 8'hFF), 1'b1);
		send_beat(cell_beat(FUNC_READ, 5'd0, 6'd2, 8'h00), 1'b1);
	endtask

	// The response side holds off for a long stretch while the sender keeps
	// offering beats back to back, so the block fills and stalls its input.
	task automatic test_hold_off();
		no_gaps  = 1'b1;
		hold_len = HOLD_CYCLES;
		hold_token++;
		repeat (40) send_cell_op();
		no_gaps = 1'b0;
		drain_results();
	endtask

	// Random packets mixed with cell ops. Every so often the sender stops
	// until everything owed has come back, and now and then it sends a
	// stretch without any gaps.
	task automatic test_random_traffic();
		int pkt_count;
		pkt_count = 0;
		while (items_sent < ITEMS_TARGET) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0) begin
				// Noise: a stray byte that ends a packet, or a lone cell op.
				if ($urandom_range(0, 1) == 0)
					send_beat(packet_beat(8'($urandom), 1'b1), 1'b1);
				else
					send_cell_op();
			end
			send_packet($urandom_range(0, 19) == 0);
			if ($urandom_range(0, 29) == 0)
				send_beat(cell_beat(FUNC_CLEAR, 5'($urandom), 6'($urandom), 8'($urandom)),
					1'b1);
			pkt_count++;
			if (pkt_count % 20 == 0)
				drain_results();
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.func        <= FUNC_PACKET;
		req_ch.data_byte   <= '0;
		req_ch.packet_last <= 1'b0;
		req_ch.cell_row    <= '0;
		req_ch.cell_col    <= '0;
		err_count    = 0;
		items_sent   = 0;
		results_seen = 0;
		hold_token   = 0;
		hold_len     = 0;
		offering     = 1'b0;
		no_gaps      = 1'b0;
		burst_left   = 0;
		wipe_screen();
		end_of_packet();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The block runs its clearing pass first; send_beat simply waits on ready.
		test_packet_decode();
		test_cut_escapes();
		test_cell_ops();
		drain_results();
		test_hold_off();
		test_random_traffic();
		drain_results();

		if (due_results.size() != 0)
			report_mismatch("results never delivered", 0, due_results.size());
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
sv/osdrle_pkg.sv
sv/osdrle_if.sv
sv/osdrle_ram.sv
sv/osdrle_ctrl.sv
sv/osdrle_dp.sv
sv/osd_rle_screen_update_top.sv
test/osd_rle_screen_update_top_tb.sv
